/* hw/rtl/toeq_pkg.sv */
// Shared types and constants for the timestamp ordered event queue.
package toeq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int TAG_W  = 16;
    localparam int TIME_W = 31;
    localparam int PID_W  = 16;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] tim;
        logic [PID_W-1:0]  pid;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the request
        logic exec;     // apply the operation to the cell row
    } toeq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
    } toeq_stat_t;

endpackage

/* hw/rtl/toeq_datapath.sv */
// Cell row with parallel compare, match search and shift for the event queue.
module toeq_datapath
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  toeq_cmd_t            cmd,
    output toeq_stat_t           stat,
    input  logic [KIND_W-1:0]    in_kind,
    input  entry_t               in_entry,
    output logic [STAT_W-1:0]    res_status,
    output entry_t               res_entry,
    output logic [OCC_W-1:0]     res_occ
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    entry_t            cell_reg [QUEUE_DEPTH];
    entry_t            cell_next[QUEUE_DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    logic [KIND_W-1:0] kind_reg;
    entry_t            req_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    entry_t            out_reg, out_next;

    logic [QUEUE_DEPTH-1:0] occ_v, gt_v, tag_v, pid_v;
    logic [QUEUE_DEPTH-1:0] ins_after, tag_after, pid_after;
    logic [IW-1:0]          tag_idx, pid_idx;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            occ_v[i] = CW'(i) < count_reg;
            gt_v[i]  = occ_v[i] && (cell_reg[i].tim > req_reg.tim);
            tag_v[i] = occ_v[i] && (cell_reg[i].tag == req_reg.tag);
            pid_v[i] = occ_v[i] && (cell_reg[i].pid == req_reg.pid);
        end
        // prefix "at or after first hit" per cell
        ins_after[0] = gt_v[0];
        tag_after[0] = tag_v[0];
        pid_after[0] = pid_v[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            ins_after[i] = ins_after[i-1] | gt_v[i];
            tag_after[i] = tag_after[i-1] | tag_v[i];
            pid_after[i] = pid_after[i-1] | pid_v[i];
        end
        tag_idx = '0;
        pid_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (tag_v[i]) tag_idx = IW'(i);
            if (pid_v[i]) pid_idx = IW'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) cell_next[i] = cell_reg[i];
        count_next  = count_reg;
        status_next = ST_OK;
        out_next    = '0;
        case (kind_reg)
            KIND_INSERT: begin
                if (count_reg == CW'(QUEUE_DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    if (ins_after[0] || !occ_v[0]) cell_next[0] = req_reg;
                    for (int i = 1; i < QUEUE_DEPTH; i++) begin
                        if (ins_after[i-1]) begin
                            cell_next[i] = cell_reg[i-1];
                        end else if (ins_after[i] || (!occ_v[i] && occ_v[i-1])) begin
                            cell_next[i] = req_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_PEEK, KIND_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    out_next = cell_reg[0];
                    if (kind_reg == KIND_POP) begin
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                            cell_next[i] = cell_reg[i+1];
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            KIND_REMOVE: begin
                if (!tag_after[QUEUE_DEPTH-1]) begin
                    status_next = ST_MISSING;
                end else begin
                    out_next = cell_reg[tag_idx];
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                        if (tag_after[i]) cell_next[i] = cell_reg[i+1];
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_FIND: begin
                if (!pid_after[QUEUE_DEPTH-1]) status_next = ST_MISSING;
                else out_next = cell_reg[pid_idx];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            req_reg  <= in_entry;
        end
        if (cmd.exec) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) cell_reg[i] <= cell_next[i];
            status_reg <= status_next;
            out_reg    <= out_next;
        end
        if (!aresetn) count_reg <= '0;
        else if (cmd.exec) count_reg <= count_next;
    end

    assign stat.busy  = 1'b0;
    assign res_status = status_reg;
    assign res_entry  = out_reg;
    assign res_occ    = OCC_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("count over depth");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> count_reg == $past(count_reg)) else $error("count moved idle");
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && status_next == ST_FULL |=> count_reg == CW'(QUEUE_DEPTH))
        else $error("full insert changed count");
endmodule

/* hw/rtl/toeq_ctrl.sv */
// Handshake controller for the event queue.
module toeq_ctrl
    import toeq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output toeq_cmd_t  cmd,
    input  toeq_stat_t stat
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_EXEC;
            S_EXEC: if (!stat.busy) state_next = S_OUT;
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;
    assign cmd.load = s_tready && s_tvalid;
    assign cmd.exec = state_reg == S_EXEC;

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_exec_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_tvalid) else $error("no result after exec");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("both sides open");
endmodule

/* hw/rtl/timestamp_ordered_event_queue.sv */
// Top level of the timestamp ordered event queue.
//  channel | dir | tdata fields (low bit up)                         | tuser
//  s_      | in  | event_tag[15:0] event_time[46:16] owner_pid[62:47] | kind[2:0]
//  m_      | out | found_tag[15:0] found_time[46:16] found_pid[62:47]  | status[1:0]
//          |     |   occupancy[69:63]                                 |
// Each item goes through capture, one pass over the cell row (compare, search
// and shift in parallel), then the result register; an output stall holds it.
// Reset empties the queue at once; cell contents are left as they were.
// A stalled m_ side holds the result and blocks the next item.
module timestamp_ordered_event_queue
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // event_tag, event_time, owner_pid
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // found_tag, found_time, found_pid, occupancy
    output logic [1:0]  m_tuser    // status
);
    toeq_cmd_t  cmd;
    toeq_stat_t stat;
    entry_t     in_entry, res_entry;
    logic [OCC_W-1:0] res_occ;

    assign in_entry.tag = s_tdata[15:0];
    assign in_entry.tim = s_tdata[46:16];
    assign in_entry.pid = s_tdata[62:47];

    toeq_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .cmd, .stat
    );

    toeq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_kind(s_tuser), .in_entry,
        .res_status(m_tuser), .res_entry, .res_occ
    );

    assign m_tdata = {2'b00, res_occ, res_entry.pid, res_entry.tim, res_entry.tag};
endmodule
